### sv/ktt_pkg.sv
// Package for the keyed tween table: constants, opcode and state types.
// Used by keyed_tween_table and ktt_div; depends on nothing.
package ktt_pkg;
  localparam int SlotCountDef = 32;
  localparam int FracBitsDef = 16;
  localparam int DataW = 32;
  localparam int FrameW = 31;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_PRUNE  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EASE_LINEAR = 2'd0,
    EASE_OUT    = 2'd1,
    EASE_SMOOTH = 2'd2,
    EASE_ALT    = 2'd3
  } ease_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_RDHIT,
    ST_CALC,
    ST_DIV,
    ST_SHAPE1,
    ST_SHAPE2,
    ST_SHAPE3,
    ST_PROD,
    ST_MIX,
    ST_WRITE,
    ST_SWEEP,
    ST_OUT
  } state_t;

  // One slot entry as kept in memory.
  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [31:0] frame;
    logic [31:0] value;
    logic [31:0] start;
    logic [31:0] goal;
    logic [31:0] elapsed;
  } slot_t;

  localparam int SlotW = $bits(slot_t);
endpackage

### sv/keyed_tween_table.sv
// Keyed tween table: SLOT_COUNT animation slots held in one synchronous RAM.
// An update request scans the table, one slot a cycle, for the key, the first
// free slot and the oldest frame. A hit reads the slot, eases it if the frame
// is new and writes it back; a miss writes a new entry to the free or oldest
// slot. Easing runs a bit-serial divider of 31 + FRAC_BITS steps. Prune and
// clear sweep the table. After reset a clearing pass runs before the first
// request is taken.
// One request is in work at a time; a result waits in the output register.
module keyed_tween_table #(
  parameter int SLOT_COUNT = ktt_pkg::SlotCountDef,
  parameter int FRAC_BITS  = ktt_pkg::FracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_key_id,
  input  logic signed [31:0] in_target_value,
  input  logic signed [31:0] in_delta_time,
  input  logic signed [31:0] in_duration,
  input  logic [30:0] in_frame_number,
  input  logic        in_animate_enable,
  input  logic [1:0]  in_easing_mode,
  input  logic [30:0] in_max_age,
  input  logic [63:0] in_generation_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_current_value
);
  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

  ktt_pkg::state_t st_r, st_nxt;

  // Request registers.
  logic [1:0]  op_r;
  logic [31:0] key_r, tgt_r, dt_r, dur_r;
  logic [30:0] frm_r, age_r;
  logic        en_r;
  logic [1:0]  mode_r;

  // Scan state.
  logic [CW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt, free_r, free_nxt;
  logic [AW-1:0] hidx_r, hidx_nxt, fidx_r, fidx_nxt, oidx_r, oidx_nxt;
  logic [31:0]   ofrm_r, ofrm_nxt;
  logic          rvld_r, rvld_nxt;
  logic [AW-1:0] raddr_r;

  // Arithmetic registers.
  ktt_pkg::slot_t ent_r, rd_ent, wr_ent;
  logic [31:0]   el_r;
  logic [FRAC_BITS+1:0] s_r;
  logic [2*FRAC_BITS+3:0] sq_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] res_r;
  logic          outv_r;
  logic [63:0]   stored_gen_r;
  logic          boot_r;

  // Memory ports.
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;

  // Divider.
  logic          div_start, div_done;
  logic [FRAC_BITS:0] div_q;

  ktt_ram #(.WIDTH(ktt_pkg::SlotW), .DEPTH(SLOT_COUNT)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_ent),
    .rd_addr(rd_addr), .rd_data(rd_ent)
  );

  ktt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(el_r[30:0]),
    .den(dur_r[30:0]), .done(div_done), .quo(div_q)
  );

  logic accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (st_r != ktt_pkg::ST_IDLE) || outv_r;
  assign out_valid = outv_r;
  assign out_current_value = res_r;

  // Combinational update helpers.
  logic        goal_chg;
  logic [31:0] base_el, start_v;
  logic signed [32:0] el_sum;
  logic [31:0] el_new;
  logic        jump;
  logic signed [32:0] diff;
  logic signed [63:0] floor_v;
  logic [31:0] fdelta;

  always_comb begin
    goal_chg = ent_r.goal != tgt_r;
    base_el  = goal_chg ? 32'd0 : ent_r.elapsed;
    start_v  = goal_chg ? ent_r.value : ent_r.start;
    el_sum   = $signed({1'b0, base_el}) +
               (dt_r[31] ? 33'sd0 : $signed({1'b0, dt_r}));
    if (el_sum > 33'sh07FFFFFFF) begin
      el_new = 32'h7FFFFFFF;
    end else if (el_sum < 0) begin
      el_new = 32'd0;
    end else begin
      el_new = el_sum[31:0];
    end
    jump   = !en_r || dur_r[31] || dur_r == 32'd0;
    diff   = $signed({tgt_r[31], tgt_r}) - $signed({ent_r.start[31], ent_r.start});
    floor_v = prod_r >>> FRAC_BITS;
    fdelta = ent_r.start + floor_v[31:0];
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ktt_pkg::ST_IDLE: begin
        if (accept) begin
          case (ktt_pkg::op_t'(in_opcode))
            ktt_pkg::OP_UPDATE: st_nxt = ktt_pkg::ST_SCAN;
            ktt_pkg::OP_PRUNE, ktt_pkg::OP_CLEAR: st_nxt = ktt_pkg::ST_SWEEP;
            default: st_nxt = ktt_pkg::ST_OUT;
          endcase
        end
      end
      ktt_pkg::ST_SCAN: begin
        if (rvld_r && raddr_r == AW'(SLOT_COUNT - 1)) st_nxt = ktt_pkg::ST_PICK;
      end
      ktt_pkg::ST_PICK:  st_nxt = hit_r ? ktt_pkg::ST_RDHIT : ktt_pkg::ST_WRITE;
      ktt_pkg::ST_RDHIT: st_nxt = ktt_pkg::ST_CALC;
      ktt_pkg::ST_CALC: begin
        if (ent_r.frame == {1'b0, frm_r}) st_nxt = ktt_pkg::ST_WRITE;
        else st_nxt = ktt_pkg::ST_DIV;
      end
      ktt_pkg::ST_DIV: begin
        if (!div_start && div_done) st_nxt = ktt_pkg::ST_SHAPE1;
      end
      ktt_pkg::ST_SHAPE1: st_nxt = ktt_pkg::ST_SHAPE2;
      ktt_pkg::ST_SHAPE2: st_nxt = ktt_pkg::ST_SHAPE3;
      ktt_pkg::ST_SHAPE3: st_nxt = ktt_pkg::ST_PROD;
      ktt_pkg::ST_PROD:   st_nxt = ktt_pkg::ST_MIX;
      ktt_pkg::ST_MIX:    st_nxt = ktt_pkg::ST_WRITE;
      ktt_pkg::ST_WRITE:  st_nxt = ktt_pkg::ST_OUT;
      ktt_pkg::ST_SWEEP: begin
        if (rvld_r && raddr_r == AW'(SLOT_COUNT - 1)) st_nxt = ktt_pkg::ST_OUT;
      end
      ktt_pkg::ST_OUT: st_nxt = ktt_pkg::ST_IDLE;
      default: st_nxt = ktt_pkg::ST_IDLE;
    endcase
  end

  // Scan, memory and divider control.
  logic div_go_r;
  always_comb begin
    idx_nxt  = idx_r;
    hit_nxt  = hit_r;
    free_nxt = free_r;
    hidx_nxt = hidx_r;
    fidx_nxt = fidx_r;
    oidx_nxt = oidx_r;
    ofrm_nxt = ofrm_r;
    rvld_nxt = 1'b0;
    rd_addr  = idx_r[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = raddr_r;
    wr_ent   = '0;
    div_start = 1'b0;
    if (st_r == ktt_pkg::ST_IDLE) begin
      idx_nxt = '0;
      hit_nxt = 1'b0;
      free_nxt = 1'b0;
      oidx_nxt = '0;
      ofrm_nxt = 32'hFFFFFFFF;
    end
    if ((st_r == ktt_pkg::ST_SCAN || st_r == ktt_pkg::ST_SWEEP) &&
        idx_r < CW'(SLOT_COUNT)) begin
      rvld_nxt = 1'b1;
      idx_nxt  = idx_r + 1'b1;
    end
    // Examine the entry read last cycle.
    if (st_r == ktt_pkg::ST_SCAN && rvld_r) begin
      if (rd_ent.used && rd_ent.key == key_r && !hit_r) begin
        hit_nxt = 1'b1;
        hidx_nxt = raddr_r;
      end
      if (!rd_ent.used && !free_r) begin
        free_nxt = 1'b1;
        fidx_nxt = raddr_r;
      end
      if (raddr_r == '0 || rd_ent.frame < ofrm_r) begin
        ofrm_nxt = rd_ent.frame;
        oidx_nxt = raddr_r;
      end
    end
    if (st_r == ktt_pkg::ST_SWEEP && rvld_r) begin
      wr_addr = raddr_r;
      if (op_r == ktt_pkg::OP_CLEAR) begin
        wr_en = 1'b1;
      end else if (rd_ent.used &&
          ($signed({2'b0, frm_r}) - $signed({1'b0, rd_ent.frame})) >
          $signed({2'b0, age_r})) begin
        wr_en = 1'b1;
      end
    end
    if (st_r == ktt_pkg::ST_PICK) rd_addr = hidx_r;
    if (st_r == ktt_pkg::ST_DIV) div_start = div_go_r;
    if (st_r == ktt_pkg::ST_WRITE) begin
      wr_en = 1'b1;
      if (!hit_r) begin
        wr_addr = free_r ? fidx_r : oidx_r;
        wr_ent.used = 1'b1;
        wr_ent.key = key_r;
        wr_ent.frame = {1'b0, frm_r};
        wr_ent.value = tgt_r;
        wr_ent.start = tgt_r;
        wr_ent.goal = tgt_r;
        wr_ent.elapsed = '0;
      end else begin
        wr_addr = hidx_r;
        wr_ent = ent_r;
        if (!en_r) begin
          wr_ent.value = tgt_r;
          wr_ent.start = tgt_r;
          wr_ent.goal = tgt_r;
          wr_ent.elapsed = '0;
        end
      end
    end
  end

  // The power-up clearing pass is marked so that it yields no result.
  always_ff @(posedge clk) begin
    if (!rst_n) boot_r <= 1'b1;
    else if (st_r == ktt_pkg::ST_OUT) boot_r <= 1'b0;
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ktt_pkg::ST_SWEEP;
      op_r   <= ktt_pkg::OP_CLEAR;
      outv_r <= 1'b0;
      idx_r  <= '0;
      rvld_r <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
      stored_gen_r <= '0;
      div_go_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      idx_r  <= idx_nxt;
      rvld_r <= rvld_nxt;
      hit_r  <= hit_nxt;
      free_r <= free_nxt;
      div_go_r <= (st_r == ktt_pkg::ST_CALC);
      if (accept) begin
        op_r <= in_opcode;
        if (in_opcode == ktt_pkg::OP_CLEAR) stored_gen_r <= in_generation_tag;
      end
      if (st_r == ktt_pkg::ST_OUT && !boot_r) begin
        outv_r <= 1'b1;
      end
      if (outv_r && !out_stall) outv_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    raddr_r <= rd_addr;
    hidx_r <= hidx_nxt;
    fidx_r <= fidx_nxt;
    oidx_r <= oidx_nxt;
    ofrm_r <= ofrm_nxt;
    if (accept) begin
      key_r <= in_key_id;
      tgt_r <= in_target_value;
      dt_r  <= in_delta_time;
      dur_r <= in_duration;
      frm_r <= in_frame_number;
      age_r <= in_max_age;
      en_r  <= in_animate_enable;
      mode_r <= in_easing_mode;
      res_r <= '0;
    end
    case (st_r)
      ktt_pkg::ST_RDHIT: ent_r <= rd_ent;
      ktt_pkg::ST_CALC: begin
        if (ent_r.frame != {1'b0, frm_r}) begin
          ent_r.start <= start_v;
          ent_r.goal <= tgt_r;
          ent_r.elapsed <= el_new;
          ent_r.frame <= {1'b0, frm_r};
          el_r <= el_new;
        end
      end
      ktt_pkg::ST_SHAPE1: begin
        if (!dur_r[31] && dur_r != 0 && el_r < dur_r) s_r <= {1'b0, div_q};
        else s_r <= ONE;
        sq_r <= '0;
      end
      ktt_pkg::ST_SHAPE2: begin
        case (ktt_pkg::ease_t'(mode_r))
          ktt_pkg::EASE_OUT: sq_r <= (ONE - s_r) * (ONE - s_r);
          ktt_pkg::EASE_SMOOTH: sq_r <= s_r * s_r;
          default: sq_r <= '0;
        endcase
      end
      ktt_pkg::ST_MIX: begin
        if (jump) ent_r.value <= tgt_r;
        else ent_r.value <= fdelta;
      end
      ktt_pkg::ST_WRITE: begin
        if (!hit_r || !en_r) res_r <= tgt_r;
        else res_r <= ent_r.value;
      end
      default: ;
    endcase
  end

  // Shaped step and product.
  logic [FRAC_BITS+1:0] s2, shaped, shp_r;
  logic [2*FRAC_BITS+3:0] cub;
  always_comb begin
    s2 = sq_r[2*FRAC_BITS+1:FRAC_BITS];
    cub = s2 * ((ONE + ONE + ONE) - (s_r + s_r));
    case (ktt_pkg::ease_t'(mode_r))
      ktt_pkg::EASE_OUT:    shaped = ONE - s2;
      ktt_pkg::EASE_SMOOTH: shaped = cub[2*FRAC_BITS+1:FRAC_BITS];
      default:              shaped = s_r;
    endcase
  end

  logic signed [63:0] prod_c;
  assign prod_c = diff * $signed({1'b0, shp_r});

  // The shaped step and the product are each registered, in ST_SHAPE3 and ST_PROD.
  always_ff @(posedge clk) begin
    if (st_r == ktt_pkg::ST_SHAPE3) shp_r <= shaped;
    if (st_r == ktt_pkg::ST_PROD) prod_r <= prod_c;
  end
endmodule

### sv/ktt_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// Stands alone; no package needed.
module ktt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

### sv/ktt_div.sv
// Restoring divider: quotient of (num << FRAC_BITS) / den, one bit a cycle.
// Uses ktt_pkg for widths.
module ktt_div #(
  parameter int FRAC_BITS = ktt_pkg::FracBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] num,
  input  logic [30:0] den,
  output logic        done,
  output logic [FRAC_BITS:0] quo
);
  localparam int NW = 31 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [31:0]   trial;

  // One shift-subtract step per cycle.
  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done     = 1'b0;
    trial    = {rem_r[30:0], dvd_r[NW-1]};
    if (start) begin
      dvd_nxt  = {num, {FRAC_BITS{1'b0}}};
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        dvd_nxt = {dvd_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        dvd_nxt = {dvd_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
    if (!start && !busy_r && cnt_r == '0) begin
      done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  // When num < den the quotient fits below ONE; the table uses quo only then.
  assign quo = dvd_r[FRAC_BITS:0];
endmodule
